// ----- src/mtts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtts_pkg
// shared types, codes and constants of the timer task scheduler
// ----------------------------------------------------------------------------
package mtts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  // a tick fires at most this many tasks
  localparam int RESULT_CAP    = 16;
  localparam int FIRE_W        = $clog2(RESULT_CAP + 1);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_FIRED   = 3'd2,
    ST_NONE    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DECIDE,
    S_RD,
    S_UPD
  } state_t;

  typedef struct packed {
    logic [31:0] trig;
    logic [31:0] per;
    logic [31:0] rem;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_en;
    logic    rd_pick;
    logic    upd;
    logic    add_wr;
    logic    clr;
    logic    emit;
    status_t res;
    logic    last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  func;
    logic pass0;
    logic scan_last;
    logic pick_found;
    logic free_found;
    logic fire_cap;
  } stat_t;

endpackage

// ----- src/multi_task_timer_scheduler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_task_timer_scheduler_unit
// table of periodic and one-shot timer tasks with add, tick and clear words
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Every result appears
// for exactly one cycle with out_valid high and cannot be held off, so the
// receiver must take each one as it comes; out_last marks the final result
// of a word. The task table sits in a memory with one read port that is
// scanned one slot per cycle. An add, clear, unused code or a tick with
// nothing due finishes after one scan of the table. A tick first scans the
// table once; for each task it fires, it then reads the chosen slot, writes
// its update back and rescans the table for the nearest trigger time and
// the next due task.
// ----------------------------------------------------------------------------
module multi_task_timer_scheduler_unit
  import mtts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [31:0]        in_now,
  input  logic [31:0]        in_interval,
  input  logic signed [31:0] in_repeats,
  // result side, one word per strobe
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [3:0]         out_slot,
  output logic [4:0]         out_task_count,
  output logic [31:0]        out_nearest_time,
  output logic               out_last
);

  // command and status between the sequencer and the table datapath
  cmd_t  cmd;
  stat_t stat;

  mtts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mtts_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_now           (in_now),
    .in_interval      (in_interval),
    .in_repeats       (in_repeats),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_task_count   (out_task_count),
    .out_nearest_time (out_nearest_time),
    .out_last         (out_last)
  );

  // a word just taken gives no result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result right after a taken word");

  // the final result leaves the block idle, an earlier one keeps it busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("busy after final result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("idle before final result");

  // an added task is always counted
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_ADDED)) |-> (out_task_count != 5'd0))
    else $error("add reported with empty table");

  // only tick words produce more than one result
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_FIRED))
    else $error("non-final result that is not a fire");

endmodule

// ----- src/mtts_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtts_ctrl
// sequencer: scan passes, pick update and result emission
// ----------------------------------------------------------------------------
module mtts_ctrl
  import mtts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // final result of a tick: no further due task, or the fire cap reached
  logic fire_last;
  assign fire_last = !stat.pick_found || stat.fire_cap;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_last) state_nxt = S_TAIL;
      end
      S_TAIL: state_nxt = S_DECIDE;
      S_DECIDE: begin
        state_nxt = S_IDLE;
        if (stat.func == OP_TICK) begin
          if (stat.pass0) begin
            if (stat.pick_found) state_nxt = S_RD;
          end else if (!fire_last) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD:  state_nxt = S_UPD;
      S_UPD: state_nxt = S_SCAN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res = ST_NONE;
    unique case (state_r)
      S_IDLE: cmd.load    = start;
      S_SCAN: cmd.scan_en = 1'b1;
      S_TAIL: ;
      S_DECIDE: begin
        unique case (stat.func)
          OP_ADD: begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.add_wr = stat.free_found;
            cmd.res    = stat.free_found ? ST_ADDED : ST_FULL;
          end
          OP_CLEAR: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            cmd.clr  = 1'b1;
            cmd.res  = ST_CLEARED;
          end
          OP_TICK: begin
            if (stat.pass0) begin
              // first pass only chooses; nothing due gives one result
              cmd.emit = !stat.pick_found;
              cmd.last = 1'b1;
              cmd.res  = ST_NONE;
            end else begin
              cmd.emit = 1'b1;
              cmd.last = fire_last;
              cmd.res  = ST_FIRED;
            end
          end
          default: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            cmd.res  = ST_NONE;
          end
        endcase
      end
      S_RD:  cmd.rd_pick = 1'b1;
      S_UPD: cmd.upd     = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- src/mtts_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtts_dpath
// task table, scan accumulators, pick update and result registers
// ----------------------------------------------------------------------------
module mtts_dpath
  import mtts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_now,
  input  logic [31:0] in_interval,
  input  logic [31:0] in_repeats,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [4:0]  out_task_count,
  output logic [31:0] out_nearest_time,
  output logic        out_last
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

  // task table, one read and one write port
  entry_t tbl_mem [MAX_TASKS];
  entry_t rdata_r;

  logic [MAX_TASKS-1:0] valid_r, due_r;
  logic [CW-1:0]        count_r, count_nxt;

  op_t         func_r;
  logic [31:0] now_r, ival_r, loop_r;
  logic        pass0_r;

  logic [IW-1:0] idx_r, sidx_r, pick_r, free_r, fired_r;
  logic          rd_vld_r;
  logic [31:0]   near_r, pick_t_r;
  logic          near_found_r, pick_found_r, free_found_r;
  logic [FIRE_W-1:0] fire_cnt_r;

  // read port
  logic [IW-1:0] raddr;
  assign raddr = cmd.rd_pick ? pick_r : idx_r;

  always_ff @(posedge clk) begin
    rdata_r <= tbl_mem[raddr];
  end

  // pick update
  logic        remove;
  logic [31:0] rem_dec;
  assign remove  = (rdata_r.rem == 32'd0) || (rdata_r.rem == 32'd1);
  assign rem_dec = rdata_r.rem[31] ? rdata_r.rem : (rdata_r.rem - 32'd1);

  logic [31:0] new_t;
  assign new_t = now_r + ival_r;

  // write port
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  always_comb begin
    we    = cmd.add_wr || (cmd.upd && !remove);
    waddr = cmd.add_wr ? free_r : pick_r;
    if (cmd.add_wr) begin
      wdata = '{trig: new_t, per: ival_r, rem: loop_r};
    end else begin
      wdata = '{trig: rdata_r.trig + rdata_r.per, per: rdata_r.per, rem: rem_dec};
    end
  end

  always_ff @(posedge clk) begin
    if (we) tbl_mem[waddr] <= wdata;
  end

  always_comb begin
    priority if (cmd.clr)             count_nxt = '0;
    else if (cmd.add_wr)              count_nxt = count_r + 1'b1;
    else if (cmd.upd && remove)       count_nxt = count_r - 1'b1;
    else                              count_nxt = count_r;
  end

  // scan element, one slot per cycle
  logic        v_s, due_s;
  logic [31:0] t_s;
  assign v_s   = valid_r[sidx_r];
  assign t_s   = rdata_r.trig;
  assign due_s = pass0_r ? ((func_r == OP_TICK) && v_s && (t_s <= now_r)) : due_r[sidx_r];

  logic restart;
  assign restart = cmd.load || cmd.upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      due_r      <= '0;
      count_r    <= '0;
      rd_vld_r   <= 1'b0;
      idx_r      <= '0;
      pass0_r    <= 1'b0;
      fire_cnt_r <= '0;
      near_found_r <= 1'b0;
      pick_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_vld_r <= cmd.scan_en;
      if (cmd.scan_en) idx_r <= idx_r + 1'b1;
      if (cmd.load) begin
        due_r      <= '0;
        pass0_r    <= 1'b1;
        fire_cnt_r <= '0;
      end
      if (cmd.clr)    valid_r <= '0;
      if (cmd.add_wr) valid_r[free_r] <= 1'b1;
      if (cmd.upd) begin
        due_r[pick_r] <= 1'b0;
        pass0_r       <= 1'b0;
        fire_cnt_r    <= fire_cnt_r + 1'b1;
        if (remove) valid_r[pick_r] <= 1'b0;
      end
      if (restart) begin
        idx_r        <= '0;
        near_found_r <= 1'b0;
        pick_found_r <= 1'b0;
        free_found_r <= 1'b0;
      end else if (rd_vld_r) begin
        if (pass0_r && (func_r == OP_TICK)) due_r[sidx_r] <= due_s;
        if (v_s && (!near_found_r || (t_s < near_r))) near_found_r <= 1'b1;
        if (!v_s) free_found_r <= 1'b1;
        if (due_s && (!pick_found_r || (t_s < pick_t_r))) pick_found_r <= 1'b1;
      end
    end
  end

  // accumulator payload
  always_ff @(posedge clk) begin
    sidx_r <= idx_r;
    if (cmd.load) begin
      func_r <= op_t'(in_func);
      now_r  <= in_now;
      ival_r <= in_interval;
      loop_r <= in_repeats;
    end
    if (cmd.upd) fired_r <= pick_r;
    if (!restart && rd_vld_r) begin
      if (v_s && (!near_found_r || (t_s < near_r))) near_r <= t_s;
      if (!v_s && !free_found_r) free_r <= sidx_r;
      if (due_s && (!pick_found_r || (t_s < pick_t_r))) begin
        pick_r   <= sidx_r;
        pick_t_r <= t_s;
      end
    end
  end

  always_comb begin
    stat.func       = func_r;
    stat.pass0      = pass0_r;
    stat.scan_last  = (idx_r == LAST_IDX);
    stat.pick_found = pick_found_r;
    stat.free_found = free_found_r;
    stat.fire_cap   = (fire_cnt_r == FIRE_W'(RESULT_CAP));
  end

  // result registers
  logic [IW-1:0] slot_sel;
  logic [31:0]   near_sel;
  always_comb begin
    slot_sel = '0;
    near_sel = near_found_r ? near_r : 32'd0;
    unique case (cmd.res)
      ST_ADDED: begin
        slot_sel = free_r;
        near_sel = (near_found_r && (near_r < new_t)) ? near_r : new_t;
      end
      ST_FIRED:   slot_sel = fired_r;
      ST_CLEARED: near_sel = 32'd0;
      default: ;
    endcase
  end

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [3:0]  out_slot_r;
  logic [4:0]  out_count_r;
  logic [31:0] out_near_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.res;
      out_slot_r   <= 4'(slot_sel);
      out_count_r  <= 5'(count_nxt);
      out_near_r   <= near_sel;
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_task_count   = out_count_r;
  assign out_nearest_time = out_near_r;
  assign out_last         = out_last_r;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the timer task scheduler
// ----------------------------------------------------------------------------
// A queue of command words is filled up front. It starts with a short
// directed run: empty table, unused code, wrapping trigger times, equal
// trigger times, endless and counted tasks, a full table and a tick that
// fires all sixteen slots. After that come random words built around a
// running millisecond clock, so that added tasks really fall due on later
// ticks, with a little full-range noise mixed in. A clocked driver hands the
// words to the block with random gaps. A shadow copy of the task table
// predicts the result words of each accepted command. A clocked monitor
// checks every strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import mtts_pkg::*;

  localparam int SLOTS = MAX_TASKS_DEF;

  // one command word and its idle gap before it is offered
  typedef struct {
    op_t                func;
    logic [31:0]        now;
    logic [31:0]        interval;
    logic signed [31:0] repeats;
    int                 gap;
  } sched_word_t;

  // one result word as it leaves the block
  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [4:0]  task_count;
    logic [31:0] nearest_time;
    logic        last;
  } sched_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_func = OP_ADD;
  logic [31:0]        in_now = '0;
  logic [31:0]        in_interval = '0;
  logic signed [31:0] in_repeats = '0;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [3:0]         out_slot;
  logic [4:0]         out_task_count;
  logic [31:0]        out_nearest_time;
  logic               out_last;

  multi_task_timer_scheduler_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_now           (in_now),
    .in_interval      (in_interval),
    .in_repeats       (in_repeats),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_task_count   (out_task_count),
    .out_nearest_time (out_nearest_time),
    .out_last         (out_last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // shadow task table
  // --------------------------------------------------------------------------
  bit          tbl_used [SLOTS];
  logic [31:0] tbl_due [SLOTS];
  logic [31:0] tbl_period [SLOTS];
  logic [31:0] tbl_left [SLOTS];
  int          tbl_count = 0;

  sched_word_t   word_queue [$];
  sched_result_t awaited_results [$];
  int            mismatches = 0;

  // gap drawing: calm stretches offer words back to back
  bit calm = 1'b0;

  // smallest trigger time among held tasks, zero when the table is empty
  function automatic logic [31:0] earliest_trigger();
    logic [31:0] best;
    bit          found;
    best = '0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_used[i] && (!found || tbl_due[i] < best)) begin
        best = tbl_due[i];
        found = 1'b1;
      end
    end
    return best;
  endfunction

  // result word built from the table as it stands right now
  task automatic post_result(status_t st, int slot, bit last);
    sched_result_t r;
    r.status       = st;
    r.slot         = slot[3:0];
    r.task_count   = tbl_count[4:0];
    r.nearest_time = earliest_trigger();
    r.last         = last;
    awaited_results.push_back(r);
  endtask

  // apply one accepted command to the shadow table and queue its results
  task automatic advance_timer_table(sched_word_t w);
    bit          firing [SLOTS];
    int          nfire;
    int          pick;
    int          free_slot;
    logic [31:0] left;
    case (w.func)
      OP_ADD: begin
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (free_slot < 0 && !tbl_used[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          // table full, nothing changes
          post_result(ST_FULL, 0, 1'b1);
        end else begin
          tbl_used[free_slot]   = 1'b1;
          tbl_due[free_slot]    = w.now + w.interval;
          tbl_period[free_slot] = w.interval;
          tbl_left[free_slot]   = w.repeats;
          tbl_count++;
          post_result(ST_ADDED, free_slot, 1'b1);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
        tbl_count = 0;
        post_result(ST_CLEARED, 0, 1'b1);
      end
      OP_NONE: begin
        post_result(ST_NONE, 0, 1'b1);
      end
      default: begin
        // tick: collect due tasks first, each fires at most once
        nfire = 0;
        for (int i = 0; i < SLOTS; i++) begin
          firing[i] = tbl_used[i] && (tbl_due[i] <= w.now);
          if (firing[i]) nfire++;
        end
        if (nfire == 0) begin
          post_result(ST_NONE, 0, 1'b1);
        end else begin
          if (nfire > RESULT_CAP) nfire = RESULT_CAP;
          for (int k = 0; k < nfire; k++) begin
            // earliest trigger first, equal times go to the lower slot
            pick = -1;
            for (int i = 0; i < SLOTS; i++) begin
              if (firing[i] && (pick < 0 || tbl_due[i] < tbl_due[pick])) pick = i;
            end
            firing[pick] = 1'b0;
            left = tbl_left[pick];
            if (left == 32'd0 || left == 32'd1) begin
              tbl_used[pick] = 1'b0;
              tbl_count--;
            end else begin
              tbl_due[pick] = tbl_due[pick] + tbl_period[pick];
              // negative counts repeat without end
              if (!left[31]) tbl_left[pick] = left - 32'd1;
            end
            post_result(ST_FIRED, pick, k == nfire - 1);
          end
        end
      end
    endcase
  endtask

  task automatic queue_word(op_t f, logic [31:0] now, logic [31:0] ival,
                            logic signed [31:0] loops);
    sched_word_t w;
    w.func       = f;
    w.now        = now;
    w.interval   = ival;
    w.repeats    = loops;
    w.gap        = calm ? 0 : $urandom_range(0, 12);
    word_queue.push_back(w);
  endtask

  // --------------------------------------------------------------------------
  // driver: start stays up until busy is seen low at an edge
  // --------------------------------------------------------------------------
  sched_word_t cur_word;
  bit          have_word = 1'b0;
  int          wait_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // word taken at this edge
        advance_timer_table(cur_word);
        have_word = 1'b0;
      end
      if (!have_word && word_queue.size() != 0) begin
        cur_word  = word_queue.pop_front();
        have_word = 1'b1;
        wait_left = cur_word.gap;
      end
      if (!(start && busy)) begin
        if (have_word && wait_left == 0) begin
          start         <= 1'b1;
          in_func       <= cur_word.func;
          in_now        <= cur_word.now;
          in_interval   <= cur_word.interval;
          in_repeats    <= cur_word.repeats;
        end else begin
          start <= 1'b0;
          if (have_word) wait_left--;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: results cannot be held off, so each strobe is checked as it comes
  // --------------------------------------------------------------------------
  sched_result_t seen;
  sched_result_t wanted;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen.status       = status_t'(out_status);
      seen.slot         = out_slot;
      seen.task_count   = out_task_count;
      seen.nearest_time = out_nearest_time;
      seen.last         = out_last;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d count %0d nearest %h last %b",
                   seen.status, seen.slot, seen.task_count, seen.nearest_time, seen.last);
      end else begin
        wanted = awaited_results.pop_front();
        if (seen.status !== wanted.status || seen.slot !== wanted.slot ||
            seen.task_count !== wanted.task_count ||
            seen.nearest_time !== wanted.nearest_time || seen.last !== wanted.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d slot %0d count %0d nearest %h last %b, %s",
                     wanted.status, wanted.slot, wanted.task_count, wanted.nearest_time,
                     wanted.last,
                     $sformatf("got status %0d slot %0d count %0d nearest %h last %b",
                               seen.status, seen.slot, seen.task_count,
                               seen.nearest_time, seen.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  logic [31:0]        clock_ms;
  logic [31:0]        ival;
  logic signed [31:0] loops;
  int                 roll;

  initial begin
    // tick on an empty table, then the unused code
    queue_word(OP_TICK, 32'h0, 32'h0, 32'sh0);
    queue_word(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -32'sd1);
    // trigger wraps past the top of the range
    queue_word(OP_ADD, 32'hFFFF_FFF0, 32'h20, 32'sd2);
    // zero interval, zero count
    queue_word(OP_ADD, 32'h0, 32'h0, 32'sh0);
    // largest interval, most negative count
    queue_word(OP_ADD, 32'h5, 32'hFFFF_FFFF, 32'sh8000_0000);
    // same trigger time as slot 0, one-shot
    queue_word(OP_ADD, 32'h0, 32'h10, 32'sd1);
    queue_word(OP_TICK, 32'h10, 32'h0, 32'sh0);
    queue_word(OP_TICK, 32'hFFFF_FFFF, 32'h0, 32'sh0);
    // tasks held but none due
    queue_word(OP_TICK, 32'h0, 32'h0, 32'sh0);
    queue_word(OP_CLEAR, 32'h0, 32'h0, 32'sh0);
    // fill every slot, one more add, then fire them all at once
    for (int i = 0; i < SLOTS; i++)
      queue_word(OP_ADD, 32'h1000, i, (i == 0) ? 32'sh7FFF_FFFF :
                 (i % 2 != 0) ? -32'sd1 : 32'(i));
    queue_word(OP_ADD, 32'h1000, 32'h1, 32'sd1);
    queue_word(OP_TICK, 32'hFFFF_FFFF, 32'h0, 32'sh0);
    queue_word(OP_CLEAR, 32'h0, 32'h0, 32'sh0);

    // random part around a moving clock, re-based now and then
    clock_ms = $urandom();
    for (int n = 0; n < 440; n++) begin
      if (n % 60 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                                : $urandom();
      end
      roll = $urandom_range(0, 99);
      if (roll < 44) begin
        ival = $urandom_range(0, 40);
        case ($urandom_range(0, 9))
          0, 1:    loops = 32'sh0;
          2, 3:    loops = 32'sd1;
          4, 5:    loops = $urandom_range(2, 4);
          6, 7:    loops = -32'sd1 - $urandom_range(0, 3);
          8:       loops = 32'sh8000_0000;
          default: loops = $urandom();
        endcase
        queue_word(OP_ADD, clock_ms, ival, loops);
      end else if (roll < 88) begin
        clock_ms = clock_ms + $urandom_range(0, 25);
        queue_word(OP_TICK, clock_ms, $urandom(), $urandom());
      end else if (roll < 91) begin
        queue_word(OP_CLEAR, $urandom(), $urandom(), $urandom());
      end else begin
        // full-range noise
        queue_word(op_t'($urandom_range(0, 2)), $urandom(), $urandom(), $urandom());
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (word_queue.size() != 0 || have_word || awaited_results.size() != 0)
      @(posedge clk);
    // let any stray result show up
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #1_500_000;
    $display("testbench failed");
    $finish;
  end

endmodule
